FILE: rtl/core/line_rasterizer_top_defines.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef LINE_RASTERIZER_TOP_DEFINES_SVH
`define LINE_RASTERIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define LR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every edge, reset included.
`define LR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LR_ASSERT(label, prop, msg)
`define LR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/core/lr_pkg.sv
// Types and constants shared by the line rasterizer.
package lr_pkg;

   localparam int COORD_BITS       = 11;
   localparam int ERR_BITS         = COORD_BITS + 3;
   localparam int ADDR_BITS        = 2 * COORD_BITS;
   localparam int ROW_WIDTH_BITS   = 12;
   localparam int COLOR_BITS       = 32;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = ROW_WIDTH_BITS'(640);

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;

   // Classified command, as it sits in the queue.
   typedef struct packed {
      logic                        is_start;
      coord_type                   pos_x;
      coord_type                   pos_y;
      coord_type                   major_end;
      coord_type                   span_major;
      coord_type                   span_minor;
      logic signed [ERR_BITS-1:0]  error_init;
      logic                        minor_down;
      logic                        x_is_major;
      logic [COLOR_BITS-1:0]       color;
   } lr_cmd_type;

   typedef struct packed {
      logic       valid;
      lr_cmd_type cmd;
   } lr_push_type;

   typedef struct packed {
      logic       valid;
      lr_cmd_type cmd;
   } lr_head_type;

endpackage

FILE: rtl/core/lr_ifs.sv
// Channel interfaces: request, pixel response and register write.
interface lr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [lr_pkg::COORD_BITS-1:0] x_start;
   logic [lr_pkg::COORD_BITS-1:0] y_start;
   logic [lr_pkg::COORD_BITS-1:0] x_end;
   logic [lr_pkg::COORD_BITS-1:0] y_end;
   logic [lr_pkg::COLOR_BITS-1:0] draw_color;

   modport source (output valid, func, x_start, y_start, x_end, y_end, draw_color,
                   input ready);
   modport sink (input valid, func, x_start, y_start, x_end, y_end, draw_color,
                 output ready);
endinterface

interface lr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lr_pkg::COORD_BITS-1:0] pixel_x;
   logic [lr_pkg::COORD_BITS-1:0] pixel_y;
   logic [lr_pkg::ADDR_BITS-1:0]  pixel_address;
   logic [lr_pkg::COLOR_BITS-1:0] pixel_color;
   logic                          last;

   modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                 output ready);
endinterface

interface lr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lr_pkg::ROW_WIDTH_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/lr_front.sv
// Front end: takes request transactions, classifies start commands and pushes start and step commands to the queue.
module lr_front (
   lr_req_if.sink             req,
   input  logic               full,
   output lr_pkg::lr_push_type push
);

   logic signed [lr_pkg::COORD_BITS:0] dx;
   logic signed [lr_pkg::COORD_BITS:0] dy;
   logic signed [lr_pkg::COORD_BITS:0] adx_w;
   logic signed [lr_pkg::COORD_BITS:0] ady_w;
   lr_pkg::coord_type adx;
   lr_pkg::coord_type ady;
   lr_pkg::coord_type xs;
   lr_pkg::coord_type ys;
   lr_pkg::coord_type xe;
   lr_pkg::coord_type ye;
   logic x_major;
   logic swap;
   logic signed [lr_pkg::ERR_BITS-1:0] two_minor;
   logic signed [lr_pkg::ERR_BITS-1:0] major_ext;

   assign req.ready = !full;

   always_comb begin
      dx    = $signed({1'b0, req.x_end}) - $signed({1'b0, req.x_start});
      dy    = $signed({1'b0, req.y_end}) - $signed({1'b0, req.y_start});
      adx_w = dx[lr_pkg::COORD_BITS] ? -dx : dx;
      ady_w = dy[lr_pkg::COORD_BITS] ? -dy : dy;
      adx   = adx_w[lr_pkg::COORD_BITS-1:0];
      ady   = ady_w[lr_pkg::COORD_BITS-1:0];

      x_major = adx > ady;
      swap    = x_major ? dx[lr_pkg::COORD_BITS] : dy[lr_pkg::COORD_BITS];

      // order so the major coordinate climbs
      xs = swap ? req.x_end   : req.x_start;
      ys = swap ? req.y_end   : req.y_start;
      xe = swap ? req.x_start : req.x_end;
      ye = swap ? req.y_start : req.y_end;

      push.valid          = req.valid && !full;
      push.cmd.is_start   = (req.func == lr_pkg::FUNC_START);
      push.cmd.pos_x      = xs;
      push.cmd.pos_y      = ys;
      push.cmd.x_is_major = x_major;
      push.cmd.major_end  = x_major ? xe : ye;
      push.cmd.span_major = x_major ? adx : ady;
      push.cmd.span_minor = x_major ? ady : adx;
      push.cmd.minor_down = x_major ? (ye < ys) : (xe < xs);
      push.cmd.color      = req.draw_color;

      two_minor = $signed(lr_pkg::ERR_BITS'({push.cmd.span_minor, 1'b0}));
      major_ext = $signed(lr_pkg::ERR_BITS'(push.cmd.span_major));
      push.cmd.error_init = two_minor - major_ext;
   end

endmodule

FILE: rtl/core/lr_queue.sv
// Command queue between front and back end.
`include "line_rasterizer_top_defines.svh"

module lr_queue (
   input  logic                clock,
   input  logic                reset,
   input  lr_pkg::lr_push_type push,
   output logic                full,
   input  logic                pop,
   output lr_pkg::lr_head_type head
);

   lr_pkg::lr_cmd_type entries_ff [lr_pkg::QUEUE_DEPTH];
   logic [lr_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [lr_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [lr_pkg::QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full       = (count_ff == lr_pkg::QUEUE_COUNT_BITS'(lr_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   `LR_ASSERT(a_count_bound, count_ff <= lr_pkg::QUEUE_COUNT_BITS'(lr_pkg::QUEUE_DEPTH), "queue count past depth")
   `LR_ASSERT(a_ptr_gap, (wr_ptr_ff - rd_ptr_ff) == lr_pkg::QUEUE_PTR_BITS'(count_ff), "queue pointers disagree with count")

endmodule

FILE: rtl/core/lr_back.sv
// Back end: Bresenham stepping and the registered pixel output.
`include "line_rasterizer_top_defines.svh"

module lr_back (
   input  logic                              clock,
   input  logic                              reset,
   input  lr_pkg::lr_head_type               head,
   output logic                              pop,
   input  logic [lr_pkg::ROW_WIDTH_BITS-1:0] row_width,
   lr_rsp_if.source                          rsp
);

   lr_pkg::coord_type pos_x_ff, pos_x_in;
   lr_pkg::coord_type pos_y_ff, pos_y_in;
   lr_pkg::coord_type major_end_ff, major_end_in;
   lr_pkg::coord_type span_major_ff, span_major_in;
   lr_pkg::coord_type span_minor_ff, span_minor_in;
   logic signed [lr_pkg::ERR_BITS-1:0] error_ff, error_in;
   logic minor_down_ff, minor_down_in;
   logic x_is_major_ff, x_is_major_in;
   logic [lr_pkg::COLOR_BITS-1:0] color_ff, color_in;
   logic busy_ff, busy_in;

   logic rsp_valid_ff, rsp_valid_in;
   lr_pkg::coord_type rsp_x_ff;
   lr_pkg::coord_type rsp_y_ff;
   logic [lr_pkg::ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic [lr_pkg::COLOR_BITS-1:0] rsp_color_ff;
   logic rsp_last_ff;

   logic emit;
   logic is_last;
   lr_pkg::coord_type minor_pos;
   lr_pkg::coord_type minor_next;
   logic signed [lr_pkg::ERR_BITS-1:0] two_minor;
   logic signed [lr_pkg::ERR_BITS-1:0] two_major;
   logic [lr_pkg::COORD_BITS+lr_pkg::ROW_WIDTH_BITS-1:0] row_product;

   assign pop  = head.valid && (!rsp_valid_ff || rsp.ready);
   assign emit = pop && !head.cmd.is_start && busy_ff;

   assign is_last = (x_is_major_ff ? pos_x_ff : pos_y_ff) == major_end_ff;

   always_comb begin
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      major_end_in  = major_end_ff;
      span_major_in = span_major_ff;
      span_minor_in = span_minor_ff;
      error_in      = error_ff;
      minor_down_in = minor_down_ff;
      x_is_major_in = x_is_major_ff;
      color_in      = color_ff;
      busy_in       = busy_ff;

      two_minor  = $signed(lr_pkg::ERR_BITS'({span_minor_ff, 1'b0}));
      two_major  = $signed(lr_pkg::ERR_BITS'({span_major_ff, 1'b0}));
      minor_pos  = x_is_major_ff ? pos_y_ff : pos_x_ff;
      minor_next = minor_down_ff ? minor_pos - 1'b1 : minor_pos + 1'b1;

      if (pop && head.cmd.is_start) begin
         pos_x_in      = head.cmd.pos_x;
         pos_y_in      = head.cmd.pos_y;
         major_end_in  = head.cmd.major_end;
         span_major_in = head.cmd.span_major;
         span_minor_in = head.cmd.span_minor;
         error_in      = head.cmd.error_init;
         minor_down_in = head.cmd.minor_down;
         x_is_major_in = head.cmd.x_is_major;
         color_in      = head.cmd.color;
         busy_in       = 1'b1;
      end else if (emit) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            if (x_is_major_ff) begin
               pos_x_in = pos_x_ff + 1'b1;
            end else begin
               pos_y_in = pos_y_ff + 1'b1;
            end
            if (error_ff[lr_pkg::ERR_BITS-1]) begin
               error_in = error_ff + two_minor;
            end else begin
               if (x_is_major_ff) begin
                  pos_y_in = minor_next;
               end else begin
                  pos_x_in = minor_next;
               end
               error_in = error_ff + two_minor - two_major;
            end
         end
      end
   end

   always_comb begin
      row_product = pos_y_ff * row_width;
      rsp_addr_in = lr_pkg::ADDR_BITS'(row_product) + lr_pkg::ADDR_BITS'(pos_x_ff);
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      major_end_ff  <= major_end_in;
      span_major_ff <= span_major_in;
      span_minor_ff <= span_minor_in;
      error_ff      <= error_in;
      minor_down_ff <= minor_down_in;
      x_is_major_ff <= x_is_major_in;
      color_ff      <= color_in;
      if (emit) begin
         rsp_x_ff     <= pos_x_ff;
         rsp_y_ff     <= pos_y_ff;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= is_last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pixel_x       = rsp_x_ff;
   assign rsp.pixel_y       = rsp_y_ff;
   assign rsp.pixel_address = rsp_addr_ff;
   assign rsp.pixel_color   = rsp_color_ff;
   assign rsp.last          = rsp_last_ff;

   `LR_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid_ff && !busy_ff, "state not cleared by reset")
   `LR_ASSERT(a_start_arms, (pop && head.cmd.is_start) |=> busy_ff, "start did not arm a line")
   `LR_ASSERT(a_last_ends, (emit && is_last) |=> !busy_ff, "line still active after last pixel")
   `LR_ASSERT(a_emit_needs_line, emit |-> busy_ff && !head.cmd.is_start, "pixel emitted with no line")

endmodule

FILE: rtl/core/line_rasterizer_top.sv
// Line rasterizer top level: register, front end, queue and back end.
// Bresenham line rasterizer. A start transaction (func 0) loads two endpoints
// and a colour and produces no pixel; each step transaction (func 1) produces
// one pixel with its framebuffer word offset x + y*row_width, with last set
// on the final pixel; a step with no line active produces nothing. Both
// channels move one transaction per clock in steady state while rsp is
// ready and the queue has room: the back end's Bresenham update (with the
// row-width multiply into the output register) sets that rate. A taken
// step transaction is written into the four-entry command queue, and its
// pixel is valid on rsp once the back end pops it and loads the output
// register. row_width is written on csr, which is always ready, and must only
// change while no transactions are in flight.
module line_rasterizer_top (
   input  logic    clock,
   input  logic    reset,
   lr_req_if.sink  req_if,
   lr_rsp_if.source rsp_if,
   lr_csr_if.sink  csr_if
);

   logic [lr_pkg::ROW_WIDTH_BITS-1:0] row_width_ff, row_width_in;
   lr_pkg::lr_push_type push;
   lr_pkg::lr_head_type head;
   logic full;
   logic pop;

   assign csr_if.ready = 1'b1;
   assign row_width_in = csr_if.valid ? csr_if.data : row_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= lr_pkg::ROW_WIDTH_RESET;
      end else begin
         row_width_ff <= row_width_in;
      end
   end

   lr_front u_front (
      .req  (req_if),
      .full (full),
      .push (push)
   );

   lr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .pop   (pop),
      .head  (head)
   );

   lr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .row_width (row_width_ff),
      .rsp       (rsp_if)
   );

endmodule
